// File: sv/segment_aabb_intersect_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment / box intersection block
// Implication checks that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_AABB_INTERSECT_TOP_MACROS_SVH
`define SEGMENT_AABB_INTERSECT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SAB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Widths, types and defaults shared by the segment / box intersection block.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int COORD_W   = 24;  // Q16.8 coordinate
    localparam int DIFF_W    = 25;  // difference of two coordinates
    localparam int FRAC_W    = 24;  // crossing fraction bits
    localparam int PROD_W    = DIFF_W + FRAC_W + 1;
    localparam int QUO_W     = PROD_W - FRAC_W;
    localparam int CROSS_W   = COORD_W + 3;
    localparam int NUM_AXES  = 3;
    localparam int NUM_FACES = 6;
    localparam int DIV_BPS   = 2;   // quotient bits per divider stage

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [COORD_W-1:0]        mag_t;
    typedef logic [FRAC_W-1:0]         frac_t;

    // item context carried down the pipe
    typedef struct packed {
        coord_t [NUM_AXES-1:0]  s;
        diff_t  [NUM_AXES-1:0]  d;
        coord_t [NUM_AXES-1:0]  bmin;
        coord_t [NUM_AXES-1:0]  bmax;
        logic                   rej;
        logic                   ins;
        logic [NUM_FACES-1:0]   strad;
    } item_t;

endpackage

// File: sv/sab_in_if.sv
// ----------------------------------------------------------------------------
// sab_in_if
// Input channel: one segment and one box per word.
// ----------------------------------------------------------------------------
interface sab_in_if;
    logic             valid;
    logic             ready;
    sab_pkg::coord_t  seg_start_x;
    sab_pkg::coord_t  seg_start_y;
    sab_pkg::coord_t  seg_start_z;
    sab_pkg::coord_t  seg_end_x;
    sab_pkg::coord_t  seg_end_y;
    sab_pkg::coord_t  seg_end_z;
    sab_pkg::coord_t  box_min_x;
    sab_pkg::coord_t  box_min_y;
    sab_pkg::coord_t  box_min_z;
    sab_pkg::coord_t  box_max_x;
    sab_pkg::coord_t  box_max_y;
    sab_pkg::coord_t  box_max_z;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_start_z,
               seg_end_x, seg_end_y, seg_end_z,
               box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_start_z,
               seg_end_x, seg_end_y, seg_end_z,
               box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

// File: sv/sab_out_if.sv
// ----------------------------------------------------------------------------
// sab_out_if
// Result channel: one hit flag per word.
// ----------------------------------------------------------------------------
interface sab_out_if;
    logic valid;
    logic ready;
    logic hits_box;

    modport source (output valid, hits_box, input ready);
    modport sink   (input valid, hits_box, output ready);
endinterface

// File: sv/segment_aabb_intersect_top.sv
// ----------------------------------------------------------------------------
// segment_aabb_intersect_top
// Segment versus axis-aligned box hit test, Q16.8 fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one word holds a segment (start, end) and a box (min, max corner).
//   result : one word per item, hits_box = 1 when the segment meets the box.
//   A word is taken on each clock edge with valid and ready high.
//   Throughput is one item per cycle while the receiver keeps ready high. The
//   pipe holds one setup stage, the six face dividers at DIV_BITS quotient
//   bits per stage, a multiply stage, a crossing-point stage and the output
//   register.
//   The whole pipe advances together; when the receiver holds ready low with a
//   result waiting, the pipe freezes and item.ready drops in the same cycle, so
//   nothing is dropped or repeated.
//   Reset clears all valid bits; no result is shown until an item enters.
// ----------------------------------------------------------------------------
`include "segment_aabb_intersect_top_macros.svh"

module segment_aabb_intersect_top #(
    parameter int DIV_BITS = sab_pkg::DIV_BPS
) (
    input  logic          clk,
    input  logic          rst_n,
    sab_in_if.sink        item,
    sab_out_if.source     result
);

    localparam int NA   = sab_pkg::NUM_AXES;
    localparam int NF   = sab_pkg::NUM_FACES;
    localparam int NST  = sab_pkg::FRAC_W / DIV_BITS;
    localparam int FW   = sab_pkg::FRAC_W;
    localparam int PW   = sab_pkg::PROD_W;
    localparam int QTW  = sab_pkg::QUO_W;
    localparam int CW   = sab_pkg::CROSS_W;

    logic en;

    sab_pkg::coord_t s_in [NA];
    sab_pkg::coord_t e_in [NA];
    sab_pkg::coord_t mn_in [NA];
    sab_pkg::coord_t mx_in [NA];

    assign s_in[0]  = item.seg_start_x;
    assign s_in[1]  = item.seg_start_y;
    assign s_in[2]  = item.seg_start_z;
    assign e_in[0]  = item.seg_end_x;
    assign e_in[1]  = item.seg_end_y;
    assign e_in[2]  = item.seg_end_z;
    assign mn_in[0] = item.box_min_x;
    assign mn_in[1] = item.box_min_y;
    assign mn_in[2] = item.box_min_z;
    assign mx_in[0] = item.box_max_x;
    assign mx_in[1] = item.box_max_y;
    assign mx_in[2] = item.box_max_z;

    // global advance: the output register is free or being drained
    assign en         = !result.valid || result.ready;
    assign item.ready = en;

    // ---------------- stage 1: slab reject, inside test, face setup ----------
    sab_pkg::item_t st1_next, st1_reg;
    sab_pkg::mag_t  num_next [NF];
    sab_pkg::mag_t  den_next [NF];
    sab_pkg::mag_t  num_reg  [NF];
    sab_pkg::mag_t  den_reg  [NF];
    logic           v1_reg;

    always_comb
    begin
        sab_pkg::diff_t se, ee, bb, d1, d2, dd;
        st1_next.rej   = 1'b0;
        st1_next.ins   = 1'b1;
        st1_next.strad = '0;
        for (int a = 0; a < NA; a++)
        begin
            st1_next.s[a]    = s_in[a];
            st1_next.bmin[a] = mn_in[a];
            st1_next.bmax[a] = mx_in[a];
            st1_next.d[a]    = sab_pkg::diff_t'(e_in[a]) - sab_pkg::diff_t'(s_in[a]);
            if ((s_in[a] < mn_in[a] && e_in[a] < mn_in[a]) ||
                (s_in[a] > mx_in[a] && e_in[a] > mx_in[a]))
                st1_next.rej = 1'b1;
            if (!(s_in[a] > mn_in[a] && s_in[a] < mx_in[a]))
                st1_next.ins = 1'b0;
        end
        // faces: min x, y, z then max x, y, z
        for (int side = 0; side < 2; side++)
        begin
            for (int a = 0; a < NA; a++)
            begin
                se = sab_pkg::diff_t'(s_in[a]);
                ee = sab_pkg::diff_t'(e_in[a]);
                bb = sab_pkg::diff_t'((side == 0) ? mn_in[a] : mx_in[a]);
                d1 = se - bb;
                d2 = ee - bb;
                dd = ee - se;
                st1_next.strad[side*NA + a] = (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);
                num_next[side*NA + a] = sab_pkg::mag_t'((d1 < 0) ? -d1 : d1);
                den_next[side*NA + a] = sab_pkg::mag_t'((dd < 0) ? -dd : dd);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg <= st1_next;
            for (int f = 0; f < NF; f++)
            begin
                num_reg[f] <= num_next[f];
                den_reg[f] <= den_next[f];
            end
        end
    end

    // ---------------- divider stages: crossing fraction per face -------------
    sab_pkg::frac_t t_face [NF];

    for (genvar f = 0; f < NF; f++)
    begin : g_div
        sab_div #(
            .DW  (sab_pkg::COORD_W),
            .QW  (FW),
            .BPS (DIV_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[f]),
            .den (den_reg[f]),
            .quo (t_face[f])
        );
    end

    // context travels beside the dividers
    sab_pkg::item_t pl_reg [NST];
    logic [NST-1:0] vd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[NST-2:0], v1_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
                pl_reg[i] <= (i == 0) ? st1_reg : pl_reg[(i == 0) ? 0 : i - 1];
        end
    end

    // ---------------- multiply: (e - s) * t on the two other axes ------------
    logic signed [PW-1:0] prod_next [NF][2];
    logic signed [PW-1:0] prod_reg  [NF][2];
    sab_pkg::item_t       mpl_reg;
    logic                 vm_reg;

    always_comb
    begin
        int a, c;
        for (int f = 0; f < NF; f++)
        begin
            a = (f < NA) ? f : f - NA;
            for (int k = 0; k < 2; k++)
            begin
                c = (k == 0) ? ((a == 0) ? 1 : 0) : ((a == 2) ? 1 : 2);
                prod_next[f][k] = PW'(pl_reg[NST-1].d[c] * $signed({1'b0, t_face[f]}));
            end
        end
    end

    // ---------------- crossing point: s + trunc(prod / 2^FW) -----------------
    logic signed [CW-1:0] h_next [NF][2];
    logic signed [CW-1:0] h_reg  [NF][2];
    sab_pkg::item_t       hpl_reg;
    logic                 vh_reg;

    always_comb
    begin
        int a, c;
        logic signed [PW-1:0]  rnd;
        logic signed [QTW-1:0] q;
        for (int f = 0; f < NF; f++)
        begin
            a = (f < NA) ? f : f - NA;
            for (int k = 0; k < 2; k++)
            begin
                c   = (k == 0) ? ((a == 0) ? 1 : 0) : ((a == 2) ? 1 : 2);
                // bias negative products so the shift truncates toward zero
                rnd = prod_reg[f][k] +
                      ((prod_reg[f][k] < 0) ? PW'((64'd1 << FW) - 64'd1) : PW'(0));
                q   = rnd[PW-1:FW];
                h_next[f][k] = CW'(mpl_reg.s[c]) + CW'(q);
            end
        end
    end

    // ---------------- final: in-face test and result -------------------------
    logic hit_next;
    logic out_reg;
    logic vo_reg;

    always_comb
    begin
        int a, c;
        logic face_any;
        logic ok;
        face_any = 1'b0;
        for (int f = 0; f < NF; f++)
        begin
            a  = (f < NA) ? f : f - NA;
            ok = hpl_reg.strad[f];
            for (int k = 0; k < 2; k++)
            begin
                c = (k == 0) ? ((a == 0) ? 1 : 0) : ((a == 2) ? 1 : 2);
                if (!(h_reg[f][k] > CW'(hpl_reg.bmin[c]) &&
                      h_reg[f][k] < CW'(hpl_reg.bmax[c])))
                    ok = 1'b0;
            end
            face_any = face_any | ok;
        end
        hit_next = !hpl_reg.rej && (hpl_reg.ins || face_any);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vh_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= vd_reg[NST-1];
            vh_reg <= vm_reg;
            vo_reg <= vh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mpl_reg <= pl_reg[NST-1];
            hpl_reg <= mpl_reg;
            out_reg <= hit_next;
            for (int f = 0; f < NF; f++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    prod_reg[f][k] <= prod_next[f][k];
                    h_reg[f][k]    <= h_next[f][k];
                end
            end
        end
    end

    assign result.valid    = vo_reg;
    assign result.hits_box = out_reg;

    // ---------------- checks -------------------------------------------------
    `SAB_ASSERT_NEXT(a_enter, clk, rst_n, item.valid && item.ready, v1_reg)
    `SAB_ASSERT_NEXT(a_reject, clk, rst_n, vh_reg && hpl_reg.rej && en, !result.hits_box)
    `SAB_ASSERT_NEXT(a_inside, clk, rst_n,
                     vh_reg && hpl_reg.ins && !hpl_reg.rej && en, result.hits_box)
    `SAB_ASSERT_NEXT(a_freeze, clk, rst_n, !en, $stable(vd_reg) && $stable(vh_reg))

endmodule

// File: sv/sab_div.sv
// ----------------------------------------------------------------------------
// sab_div
// Pipelined restoring divider for num * 2^QW / den with num < den.
// ----------------------------------------------------------------------------
module sab_div #(
    parameter int DW  = sab_pkg::COORD_W,
    parameter int QW  = sab_pkg::FRAC_W,
    parameter int BPS = sab_pkg::DIV_BPS
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int NST = QW / BPS;

    logic [DW-1:0] rem_reg  [NST];
    logic [DW-1:0] den_reg  [NST];
    logic [QW-1:0] quo_reg  [NST];
    logic [DW-1:0] rem_next [NST];
    logic [QW-1:0] quo_next [NST];

    // BPS shift-subtract steps per stage
    always_comb
    begin
        logic [DW:0]   r;
        logic [DW:0]   dd;
        logic [QW-1:0] q;
        for (int i = 0; i < NST; i++)
        begin
            r  = {1'b0, (i == 0) ? num : rem_reg[(i == 0) ? 0 : i - 1]};
            dd = {1'b0, (i == 0) ? den : den_reg[(i == 0) ? 0 : i - 1]};
            q  = (i == 0) ? '0 : quo_reg[(i == 0) ? 0 : i - 1];
            for (int j = 0; j < BPS; j++)
            begin
                r = {r[DW-1:0], 1'b0};
                if (r >= dd)
                begin
                    r = r - dd;
                    q = {q[QW-2:0], 1'b1};
                end
                else
                begin
                    q = {q[QW-2:0], 1'b0};
                end
            end
            rem_next[i] = r[DW-1:0];
            quo_next[i] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= (i == 0) ? den : den_reg[(i == 0) ? 0 : i - 1];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quo = quo_reg[NST-1];

endmodule

// File: tb/sv/sab_tb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sab_tb_checker
// Watches both channels of the segment / box block, predicts each hit flag
// from the accepted item words and compares it with the result words in order.
// ----------------------------------------------------------------------------
module sab_tb_checker (
    input  logic     clk,
    input  logic     rst_n,
    sab_in_if.sink   item,
    sab_out_if.sink  result,
    output int       fail_count,
    output int       pending
);

    bit hit_queue [$];

    // crossing coordinate on a non-plane axis, fraction with 24 fraction bits
    function automatic longint cross_coord(longint s, longint e, longint t);
        return s + ((e - s) * t) / (longint'(1) << sab_pkg::FRAC_W);
    endfunction

    function automatic bit face_crossed(longint s[3], longint e[3], longint lo[3],
                                        longint hi[3], int a, longint b);
        longint d1, d2, num, den, t, h;
        d1 = s[a] - b;
        d2 = e[a] - b;
        if (!((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)))
            return 1'b0;
        num = (d1 < 0) ? -d1 : d1;
        den = d2 - d1;
        if (den < 0)
            den = -den;
        t = (num * (longint'(1) << sab_pkg::FRAC_W)) / den;
        for (int k = 0; k < 3; k++)
        begin
            if (k == a)
                continue;
            h = cross_coord(s[k], e[k], t);
            if (!(h > lo[k] && h < hi[k]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit predict_hit(longint s[3], longint e[3], longint lo[3],
                                       longint hi[3]);
        for (int a = 0; a < 3; a++)
        begin
            if (s[a] < lo[a] && e[a] < lo[a])
                return 1'b0;
            if (s[a] > hi[a] && e[a] > hi[a])
                return 1'b0;
        end
        if (s[0] > lo[0] && s[0] < hi[0] && s[1] > lo[1] && s[1] < hi[1] &&
            s[2] > lo[2] && s[2] < hi[2])
            return 1'b1;
        for (int a = 0; a < 3; a++)
            if (face_crossed(s, e, lo, hi, a, lo[a]))
                return 1'b1;
        for (int a = 0; a < 3; a++)
            if (face_crossed(s, e, lo, hi, a, hi[a]))
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // sample both channels at the edge
    always @(posedge clk)
    begin
        longint s[3], e[3], lo[3], hi[3];
        bit exp_hit;
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                s  = '{longint'(item.seg_start_x), longint'(item.seg_start_y),
                       longint'(item.seg_start_z)};
                e  = '{longint'(item.seg_end_x), longint'(item.seg_end_y),
                       longint'(item.seg_end_z)};
                lo = '{longint'(item.box_min_x), longint'(item.box_min_y),
                       longint'(item.box_min_z)};
                hi = '{longint'(item.box_max_x), longint'(item.box_max_y),
                       longint'(item.box_max_z)};
                hit_queue.push_back(predict_hit(s, e, lo, hi));
            end
            if (result.valid && result.ready)
            begin
                if (hit_queue.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    exp_hit = hit_queue.pop_front();
                    if (result.hits_box !== exp_hit)
                        report_mismatch($sformatf("hits_box got %b expected %b",
                                                  result.hits_box, exp_hit));
                end
            end
            pending = hit_queue.size();
        end
    end
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the segment / box hit test: directed corner cases, then random
// words mixing near-box segments and raw noise, with bursty sending, random
// receiver stalls and one long stall that fills the pipe.
// ----------------------------------------------------------------------------
module testbench;
    typedef sab_pkg::coord_t coord_t;

    localparam int N_RANDOM   = 900;
    localparam int LATENCY    = 16;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   stim_done;
    bit   long_hold;

    sab_in_if  item ();
    sab_out_if result ();

    segment_aabb_intersect_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    sab_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    typedef coord_t word_t [12];

    word_t directed [$];

    function automatic coord_t rnd_coord();
        return coord_t'($urandom);
    endfunction

    // coordinate near a small range so boxes and segments interact
    function automatic coord_t near(int c, int spread);
        return coord_t'(c + $urandom_range(0, 2 * spread) - spread);
    endfunction

    function automatic word_t make_word(coord_t s[3], coord_t e[3], coord_t lo[3],
                                        coord_t hi[3]);
        word_t w;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = s[i];
            w[3 + i] = e[i];
            w[6 + i] = lo[i];
            w[9 + i] = hi[i];
        end
        return w;
    endfunction

    function automatic word_t random_word();
        coord_t s[3], e[3], lo[3], hi[3];
        int     c, half, kind, sp;
        kind = $urandom_range(0, 9);
        c = $urandom_range(0, 1) ? 0 : int'($signed(coord_t'($urandom))) / 2;
        sp = $urandom_range(0, 1) ? 64 : 4000000;
        for (int i = 0; i < 3; i++)
        begin
            half = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(1, sp);
            lo[i] = coord_t'(c - half);
            hi[i] = coord_t'(c + half);
            s[i] = near(c, 2 * sp);
            e[i] = near(c, 2 * sp);
        end
        if (kind == 0)
        begin
            // pure noise
            for (int i = 0; i < 3; i++)
            begin
                s[i] = rnd_coord(); e[i] = rnd_coord();
                lo[i] = rnd_coord(); hi[i] = rnd_coord();
            end
        end
        else if (kind == 1)
        begin
            // endpoint on a face plane
            int a;
            a = $urandom_range(0, 2);
            s[a] = $urandom_range(0, 1) ? lo[a] : hi[a];
        end
        else if (kind == 2)
        begin
            // inverted or degenerate box on one axis
            int a;
            a = $urandom_range(0, 2);
            lo[a] = hi[a] + coord_t'($urandom_range(0, 16));
        end
        return make_word(s, e, lo, hi);
    endfunction

    // directed corner words
    initial
    begin
        coord_t s[3], e[3], lo[3], hi[3];
        coord_t mx, mn;
        mx = coord_t'(24'h7FFFFF);
        mn = coord_t'(24'h800000);
        // full-range box, segment between extremes
        s = '{mn, mn, mn}; e = '{mx, mx, mx}; lo = '{mn, mn, mn}; hi = '{mx, mx, mx};
        directed.push_back(make_word(s, e, lo, hi));
        s = '{mx, mn, mx}; e = '{mn, mx, mn};
        directed.push_back(make_word(s, e, lo, hi));
        lo = '{coord_t'(-256), coord_t'(-256), coord_t'(-256)};
        hi = '{coord_t'(256), coord_t'(256), coord_t'(256)};
        // start strictly inside
        s = '{0, 0, 0}; e = '{mx, mx, mx};
        directed.push_back(make_word(s, e, lo, hi));
        // both beyond the same face on each axis
        for (int a = 0; a < 3; a++)
        begin
            s = '{0, 0, 0}; e = '{0, 0, 0};
            s[a] = mn; e[a] = coord_t'(-300);
            directed.push_back(make_word(s, e, lo, hi));
            s[a] = mx; e[a] = coord_t'(300);
            directed.push_back(make_word(s, e, lo, hi));
            // straddle through both faces of this axis
            s[a] = mn; e[a] = mx;
            directed.push_back(make_word(s, e, lo, hi));
        end
        // start on surface, end outside
        s = '{coord_t'(-256), 0, 0}; e = '{coord_t'(-1000), 0, 0};
        directed.push_back(make_word(s, e, lo, hi));
        // start on surface, end inside-through
        s = '{coord_t'(-256), 0, 0}; e = '{coord_t'(1000), 0, 0};
        directed.push_back(make_word(s, e, lo, hi));
        // crosses the plane but misses the face
        s = '{coord_t'(-1000), coord_t'(900), 0}; e = '{coord_t'(1000), coord_t'(900), 0};
        directed.push_back(make_word(s, e, lo, hi));
        // grazes edge exactly
        s = '{coord_t'(-1000), coord_t'(256), 0}; e = '{coord_t'(1000), coord_t'(256), 0};
        directed.push_back(make_word(s, e, lo, hi));
        // degenerate box
        lo = '{0, 0, 0}; hi = '{0, 0, 0};
        s = '{coord_t'(-10), 0, 0}; e = '{coord_t'(10), 0, 0};
        directed.push_back(make_word(s, e, lo, hi));
        // inverted box
        lo = '{coord_t'(256), coord_t'(256), coord_t'(256)};
        hi = '{coord_t'(-256), coord_t'(-256), coord_t'(-256)};
        s = '{0, 0, 0}; e = '{mx, mn, mx};
        directed.push_back(make_word(s, e, lo, hi));
        // minimum-value and all-ones patterns
        s = '{mn, mn, mn}; e = '{mn, mn, mn}; lo = '{mn, mn, mn}; hi = '{mn, mn, mn};
        directed.push_back(make_word(s, e, lo, hi));
        s = '{coord_t'(-1), coord_t'(-1), coord_t'(-1)}; e = s;
        lo = '{mn, mn, mn}; hi = '{mx, mx, mx};
        directed.push_back(make_word(s, e, lo, hi));
    end

    task automatic drive_word(input word_t w, input bit vld);
        item.valid       <= vld;
        item.seg_start_x <= w[0];
        item.seg_start_y <= w[1];
        item.seg_start_z <= w[2];
        item.seg_end_x   <= w[3];
        item.seg_end_y   <= w[4];
        item.seg_end_z   <= w[5];
        item.box_min_x   <= w[6];
        item.box_min_y   <= w[7];
        item.box_min_z   <= w[8];
        item.box_max_x   <= w[9];
        item.box_max_y   <= w[10];
        item.box_max_z   <= w[11];
    endtask

    // send one word, hold until accepted
    task automatic send_word(input word_t w);
        drive_word(w, 1'b1);
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    // sender: bursts with random gaps
    initial
    begin
        word_t w;
        int    burst;
        int    sent;
        for (int i = 0; i < 12; i++)
            w[i] = '0;
        drive_word(w, 1'b0);
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_word(directed[i]);
        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++)
            begin
                send_word(random_word());
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                drive_word(random_word(), 1'b0);
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        drive_word(w, 1'b0);
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off mid run
    initial
    begin
        int mode;
        result.ready = 1'b0;
        long_hold = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold && cycle_count > 600)
            begin
                long_hold = 1'b1;
                result.ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            mode = (cycle_count / 150) % 3;
            if (mode == 0)
                result.ready <= 1'b1;
            else if (mode == 1)
                result.ready <= ($urandom_range(0, 3) != 0);
            else
                result.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog and verdict
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            if (stim_done && pending == 0)
            begin
                repeat (LATENCY + 4) @(posedge clk);
                if (fail_count == 0 && pending == 0)
                    $display("Regression PASS");
                else
                    $display("Regression FAIL");
                $finish;
            end
        end
    end
endmodule

// File: files.f
+incdir+sv
sv/sab_pkg.sv
sv/sab_in_if.sv
sv/sab_out_if.sv
sv/sab_div.sv
sv/segment_aabb_intersect_top.sv
tb/sv/sab_tb_checker.sv
tb/sv/testbench.sv
